[rtl/fasp_pkg.sv]
// Shared types, command codes and reset values of the five-axis stepper controller.
// Depends on nothing; every other file refers to it by scoped names.
package fasp_pkg;

    // Default parameter values.
    localparam int AXES_DEF     = 5;
    localparam int POS_BITS_DEF = 16;
    localparam int QUEUE_DEPTH  = 2;

    // Field widths fixed by the interface.
    localparam int CMD_W    = 8;
    localparam int CFG_W    = 16;
    localparam int SHIFT_W  = 4;
    localparam int OUT_W    = 5;
    localparam int ARG_W    = 3;
    localparam int M_DATA_W = 24;

    // Position bytes are scaled by this factor before the shift.
    localparam int POS_SCALE = 25;
    localparam int PROD_W    = CMD_W + 5;

    // Command bytes.
    localparam logic [CMD_W-1:0] CMD_HOME       = 8'h01;
    localparam logic [CMD_W-1:0] CMD_ZERO       = 8'h02;
    localparam logic [CMD_W-1:0] CMD_MAX        = 8'h03;
    localparam logic [CMD_W-1:0] CMD_POS        = 8'h05;
    localparam logic [CMD_W-1:0] CMD_DESEL_BASE = 8'h75;
    localparam logic [CMD_W-1:0] CMD_DESEL_LAST = 8'h79;
    localparam logic [CMD_W-1:0] CMD_SEL_BASE   = 8'h7A;
    localparam logic [CMD_W-1:0] CMD_SEL_LAST   = 8'h7E;
    localparam logic [CMD_W-1:0] CMD_STOP       = 8'h7F;
    localparam logic [CMD_W-1:0] CMD_SPEED_BASE = 8'hFA;

    // Configuration register indexes.
    localparam logic [2:0] CFG_IDX_ZERO  = 3'd0;
    localparam logic [2:0] CFG_IDX_HOME  = 3'd1;
    localparam logic [2:0] CFG_IDX_MAX   = 3'd2;
    localparam logic [2:0] CFG_IDX_START = 3'd3;
    localparam logic [2:0] CFG_IDX_SHIFT = 3'd4;

    // Configuration reset values.
    localparam logic [CFG_W-1:0]   ZERO_RESET  = 16'd0;
    localparam logic [CFG_W-1:0]   HOME_RESET  = 16'd100;
    localparam logic [CFG_W-1:0]   MAX_RESET   = 16'd4095;
    localparam logic [CFG_W-1:0]   START_RESET = 16'd4095;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd0;

    typedef struct packed {
        logic [CFG_W-1:0]   zero_pos;
        logic [CFG_W-1:0]   home_pos;
        logic [CFG_W-1:0]   max_pos;
        logic [CFG_W-1:0]   start_pos;
        logic [SHIFT_W-1:0] pos_shift;
    } cfg_t;

    // Classified input item.
    typedef enum logic [3:0] {
        K_TICK  = 4'd0,
        K_HOME  = 4'd1,
        K_ZERO  = 4'd2,
        K_MAX   = 4'd3,
        K_POS   = 4'd4,
        K_DESEL = 4'd5,
        K_SEL   = 4'd6,
        K_STOP  = 4'd7,
        K_SPEED = 4'd8,
        K_NONE  = 4'd9
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [ARG_W-1:0] arg;
    } cmd_t;

    localparam int CMD_T_W = $bits(cmd_t);

    // Homing sequencer.
    typedef enum logic [3:0] {
        HS_ZERO = 4'b0001,
        HS_HOME = 4'b0010,
        HS_REF  = 4'b0100,
        HS_IDLE = 4'b1000
    } hstage_t;

endpackage

[rtl/fasp_front.sv]
// Front end: classifies an input item and scales a possible position byte.
// Depends on fasp_pkg.
module fasp_front #(
    parameter int AXES          = fasp_pkg::AXES_DEF,
    parameter int POSITION_BITS = fasp_pkg::POS_BITS_DEF
) (
    input  logic                           mode_in,
    input  logic [fasp_pkg::CMD_W-1:0]     byte_in,
    input  logic [fasp_pkg::SHIFT_W-1:0]   pos_shift,
    output fasp_pkg::cmd_t                 cmd_out,
    output logic [POSITION_BITS-1:0]       pos_out
);

    localparam int WIDE_W = fasp_pkg::PROD_W + (1 << fasp_pkg::SHIFT_W) - 1;
    localparam logic [3:0] AXES_W4 = 4'(AXES);

    logic [fasp_pkg::PROD_W-1:0] prod;
    logic [WIDE_W-1:0]           wide;
    logic [fasp_pkg::ARG_W-1:0]  desel_off;
    logic [fasp_pkg::ARG_W-1:0]  sel_off;

    assign prod = fasp_pkg::PROD_W'(byte_in) * fasp_pkg::PROD_W'(fasp_pkg::POS_SCALE);
    assign wide = WIDE_W'(prod) << pos_shift;

    // Saturate to the all-ones position when the scaled value does not fit.
    generate
        if (POSITION_BITS >= WIDE_W) begin : g_fit
            assign pos_out = POSITION_BITS'(wide);
        end else begin : g_sat
            assign pos_out = (wide[WIDE_W-1:POSITION_BITS] != '0) ? '1
                                                                  : wide[POSITION_BITS-1:0];
        end
    endgenerate

    assign desel_off = fasp_pkg::ARG_W'(byte_in - fasp_pkg::CMD_DESEL_BASE);
    assign sel_off   = fasp_pkg::ARG_W'(byte_in - fasp_pkg::CMD_SEL_BASE);

    always_comb begin
        cmd_out.kind = fasp_pkg::K_NONE;
        cmd_out.arg  = '0;
        if (!mode_in) begin
            cmd_out.kind = fasp_pkg::K_TICK;
        end else if (byte_in == fasp_pkg::CMD_HOME) begin
            cmd_out.kind = fasp_pkg::K_HOME;
        end else if (byte_in == fasp_pkg::CMD_ZERO) begin
            cmd_out.kind = fasp_pkg::K_ZERO;
        end else if (byte_in == fasp_pkg::CMD_MAX) begin
            cmd_out.kind = fasp_pkg::K_MAX;
        end else if (byte_in == fasp_pkg::CMD_POS) begin
            cmd_out.kind = fasp_pkg::K_POS;
        end else if (byte_in >= fasp_pkg::CMD_DESEL_BASE
                     && byte_in <= fasp_pkg::CMD_DESEL_LAST) begin
            if ({1'b0, desel_off} < AXES_W4) begin
                cmd_out.kind = fasp_pkg::K_DESEL;
                cmd_out.arg  = desel_off;
            end
        end else if (byte_in >= fasp_pkg::CMD_SEL_BASE
                     && byte_in <= fasp_pkg::CMD_SEL_LAST) begin
            if ({1'b0, sel_off} < AXES_W4) begin
                cmd_out.kind = fasp_pkg::K_SEL;
                cmd_out.arg  = sel_off;
            end
        end else if (byte_in == fasp_pkg::CMD_STOP) begin
            cmd_out.kind = fasp_pkg::K_STOP;
        end else if (byte_in >= fasp_pkg::CMD_SPEED_BASE) begin
            cmd_out.kind = fasp_pkg::K_SPEED;
            cmd_out.arg  = fasp_pkg::ARG_W'(byte_in - fasp_pkg::CMD_SPEED_BASE);
        end
    end

endmodule

[rtl/fasp_queue.sv]
// Short register queue between the front end and the execution back end.
// Depends on fasp_pkg for its default depth.
module fasp_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = fasp_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output logic [DATA_W-1:0] head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign head_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/fasp_back.sv]
// Back end: holds the axis and homing state, executes one queued item per cycle while its
// output register can take a result, and registers the result. Depends on fasp_pkg.
module fasp_back #(
    parameter int AXES          = fasp_pkg::AXES_DEF,
    parameter int POSITION_BITS = fasp_pkg::POS_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            item_valid,
    output logic                            item_pop,
    input  fasp_pkg::cmd_t                  item_cmd,
    input  logic [POSITION_BITS-1:0]        item_pos,
    input  fasp_pkg::cfg_t                  cfg,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fasp_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int EXT_W = AXES + fasp_pkg::OUT_W;
    localparam int PAD_W = fasp_pkg::M_DATA_W - 4 * fasp_pkg::OUT_W - 2;

    typedef logic [AXES-1:0][POSITION_BITS-1:0] pos_vec_t;

    pos_vec_t                   pos_reg, pos_next;
    pos_vec_t                   tgt_reg, tgt_next;
    logic [AXES-1:0]            sel_reg, sel_next;
    logic [AXES-1:0]            inpl_reg, inpl_next;
    logic [AXES-1:0]            ref_reg, ref_next;
    logic [AXES-1:0]            lvl_reg, lvl_next;
    logic [AXES-1:0]            dir_reg, dir_next;
    logic [AXES-1:0]            awake_reg, awake_next;
    logic                       motion_reg, motion_next;
    logic                       homing_reg, homing_next;
    fasp_pkg::hstage_t          stage_reg, stage_next;
    logic                       pend_reg, pend_next;
    logic [fasp_pkg::ARG_W-1:0] speed_reg, speed_next;
    logic [fasp_pkg::ARG_W-1:0] tick_reg, tick_next;

    logic                       m_tvalid_reg;
    logic [fasp_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                       set_en;
    logic [POSITION_BITS-1:0]   set_p;
    logic [POSITION_BITS-1:0]   zero_p, home_p, max_p, start_p, tgt_c;
    logic [EXT_W-1:0]           ext_lvl, ext_dir, ext_awake, ext_ref;

    assign zero_p  = POSITION_BITS'(cfg.zero_pos);
    assign home_p  = POSITION_BITS'(cfg.home_pos);
    assign max_p   = POSITION_BITS'(cfg.max_pos);
    assign start_p = POSITION_BITS'(cfg.start_pos);

    // The output register frees its slot whenever the result is taken.
    assign item_pop = item_valid && (!m_tvalid_reg || m_tready);

    always_comb begin
        pos_next    = pos_reg;
        tgt_next    = tgt_reg;
        sel_next    = sel_reg;
        inpl_next   = inpl_reg;
        ref_next    = ref_reg;
        lvl_next    = lvl_reg;
        dir_next    = dir_reg;
        awake_next  = awake_reg;
        motion_next = motion_reg;
        homing_next = homing_reg;
        stage_next  = stage_reg;
        pend_next   = pend_reg;
        speed_next  = speed_reg;
        tick_next   = tick_reg;
        set_en      = 1'b0;
        set_p       = zero_p;
        tgt_c       = zero_p;

        // Homing sequencer on ticks, command decode on other items outside homing.
        if (item_cmd.kind == fasp_pkg::K_TICK) begin
            if (homing_reg) begin
                case (stage_reg)
                    fasp_pkg::HS_ZERO: begin
                        sel_next   = '1;
                        set_en     = 1'b1;
                        set_p      = zero_p;
                        stage_next = fasp_pkg::HS_HOME;
                    end
                    fasp_pkg::HS_HOME: begin
                        if (!motion_reg) begin
                            set_en     = 1'b1;
                            set_p      = home_p;
                            stage_next = fasp_pkg::HS_REF;
                        end
                    end
                    fasp_pkg::HS_REF: begin
                        if (!motion_reg) begin
                            ref_next    = '1;
                            sel_next    = '0;
                            homing_next = 1'b0;
                            stage_next  = fasp_pkg::HS_IDLE;
                        end
                    end
                    default: begin
                        sel_next   = '0;
                        ref_next   = '0;
                        pos_next   = {AXES{start_p}};
                        tgt_next   = {AXES{zero_p}};
                        inpl_next  = '1;
                        stage_next = fasp_pkg::HS_ZERO;
                    end
                endcase
            end
        end else if (!homing_reg) begin
            if (pend_reg) begin
                pend_next = 1'b0;
                set_en    = 1'b1;
                set_p     = item_pos;
            end else begin
                case (item_cmd.kind)
                    fasp_pkg::K_HOME:  homing_next = 1'b1;
                    fasp_pkg::K_ZERO: begin
                        set_en = 1'b1;
                        set_p  = zero_p;
                    end
                    fasp_pkg::K_MAX: begin
                        set_en = 1'b1;
                        set_p  = max_p;
                    end
                    fasp_pkg::K_POS:   pend_next = 1'b1;
                    fasp_pkg::K_DESEL: begin
                        for (int i = 0; i < AXES; i++) begin
                            if (item_cmd.arg == fasp_pkg::ARG_W'(i)) sel_next[i] = 1'b0;
                        end
                    end
                    fasp_pkg::K_SEL: begin
                        for (int i = 0; i < AXES; i++) begin
                            if (item_cmd.arg == fasp_pkg::ARG_W'(i)) sel_next[i] = 1'b1;
                        end
                    end
                    fasp_pkg::K_STOP: begin
                        awake_next  = '0;
                        motion_next = 1'b0;
                    end
                    fasp_pkg::K_SPEED: speed_next = item_cmd.arg;
                    default: ;
                endcase
            end
        end

        // New target for every selected axis, clamped to the maximum going up.
        if (set_en) begin
            for (int i = 0; i < AXES; i++) begin
                if (sel_next[i]) begin
                    if (pos_next[i] == set_p) begin
                        tgt_next[i]  = pos_next[i];
                        inpl_next[i] = 1'b1;
                    end else begin
                        tgt_c = (pos_next[i] < set_p && set_p > max_p) ? max_p : set_p;
                        tgt_next[i]   = tgt_c;
                        inpl_next[i]  = 1'b0;
                        awake_next[i] = 1'b1;
                        dir_next[i]   = (tgt_c < pos_next[i]);
                    end
                end
            end
            motion_next = !(&inpl_next);
        end

        // Step update on every (divisor + 1)-th tick.
        if (item_cmd.kind == fasp_pkg::K_TICK) begin
            if (tick_reg < speed_reg) begin
                tick_next = tick_reg + 1'b1;
            end else begin
                tick_next = '0;
                if (motion_next) begin
                    for (int i = 0; i < AXES; i++) begin
                        if (sel_next[i]) begin
                            if (tgt_next[i] == pos_next[i]) begin
                                awake_next[i] = 1'b0;
                                inpl_next[i]  = 1'b1;
                            end else begin
                                lvl_next[i] = !lvl_next[i];
                                if (tgt_next[i] > pos_next[i]) begin
                                    pos_next[i] = pos_next[i] + 1'b1;
                                end else begin
                                    pos_next[i] = pos_next[i] - 1'b1;
                                end
                            end
                        end
                    end
                    motion_next = !(&inpl_next);
                end
            end
        end
    end

    assign ext_lvl   = EXT_W'(lvl_next);
    assign ext_dir   = EXT_W'(dir_next);
    assign ext_awake = EXT_W'(awake_next);
    assign ext_ref   = EXT_W'(ref_next);
    assign m_tdata_next = {PAD_W'(0), homing_next, ext_ref[fasp_pkg::OUT_W-1:0], motion_next,
                           ext_awake[fasp_pkg::OUT_W-1:0], ext_dir[fasp_pkg::OUT_W-1:0],
                           ext_lvl[fasp_pkg::OUT_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= {AXES{POSITION_BITS'(fasp_pkg::START_RESET)}};
            tgt_reg      <= {AXES{POSITION_BITS'(fasp_pkg::ZERO_RESET)}};
            sel_reg      <= '0;
            inpl_reg     <= '0;
            ref_reg      <= '0;
            lvl_reg      <= '0;
            dir_reg      <= '0;
            awake_reg    <= '0;
            motion_reg   <= 1'b0;
            homing_reg   <= 1'b1;
            stage_reg    <= fasp_pkg::HS_ZERO;
            pend_reg     <= 1'b0;
            speed_reg    <= '0;
            tick_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (item_pop) begin
                pos_reg      <= pos_next;
                tgt_reg      <= tgt_next;
                sel_reg      <= sel_next;
                inpl_reg     <= inpl_next;
                ref_reg      <= ref_next;
                lvl_reg      <= lvl_next;
                dir_reg      <= dir_next;
                awake_reg    <= awake_next;
                motion_reg   <= motion_next;
                homing_reg   <= homing_next;
                stage_reg    <= stage_next;
                pend_reg     <= pend_next;
                speed_reg    <= speed_next;
                tick_reg     <= tick_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_pop) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A position prefix can only be pending outside homing.
    a_pend_not_homing: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !homing_reg)
        else $error("position prefix pending while homing");

    // Once homing has finished the sequencer rests in its idle stage.
    a_idle_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        !homing_reg |-> (stage_reg == fasp_pkg::HS_IDLE))
        else $error("homing stage active while homing is off");

    // All axes are referenced together or not at all.
    a_ref_uniform: assert property (@(posedge aclk) disable iff (!aresetn)
        (ref_reg == '0) || (ref_reg == '1))
        else $error("referenced mask is not uniform");

    // Every executed item leaves a result in the output register.
    a_pop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        item_pop |=> m_tvalid_reg)
        else $error("executed item produced no result");

endmodule

[rtl/five_axis_stepper_position_controller.sv]
// A transferred s_ item is registered in the queue; its result is then registered in the output register on m_.
// Throughput: one item per cycle while m_tready is high; the back end updates all axes in parallel.
// A two-entry queue decouples the front end from the back end, which owns the output register.
// Reset: aresetn is synchronous and active low; homing is active and all axes sit at the
// start position after reset, with configuration registers at their defaults.
// Depends on fasp_pkg, fasp_front, fasp_queue and fasp_back.
module five_axis_stepper_position_controller #(
    parameter int AXES          = fasp_pkg::AXES_DEF,
    parameter int POSITION_BITS = fasp_pkg::POS_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Input channel: one timer tick or one received command byte.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] cmd_byte
    input  logic [0:0]  s_tuser,    // [0] mode (0 = tick, 1 = command byte)

    // Result channel: a snapshot of the outputs after each item.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [4:0] step_levels, [9:5] dir_down, [14:10] awake_mask,
                                    // [15] moving, [20:16] referenced_mask, [21] homing,
                                    // [23:22] zero

    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int ENTRY_W = fasp_pkg::CMD_T_W + POSITION_BITS;

    fasp_pkg::cfg_t            cfg_reg;
    fasp_pkg::cmd_t            front_cmd;
    fasp_pkg::cmd_t            head_cmd;
    logic [POSITION_BITS-1:0]  front_pos;
    logic [POSITION_BITS-1:0]  head_pos;
    logic [ENTRY_W-1:0]        head_entry;
    logic                      q_full;
    logic                      q_not_empty;
    logic                      q_pop;
    logic                      s_xfer;

    // Configuration writes are always taken; indexes past the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_pos  <= fasp_pkg::ZERO_RESET;
            cfg_reg.home_pos  <= fasp_pkg::HOME_RESET;
            cfg_reg.max_pos   <= fasp_pkg::MAX_RESET;
            cfg_reg.start_pos <= fasp_pkg::START_RESET;
            cfg_reg.pos_shift <= fasp_pkg::SHIFT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                fasp_pkg::CFG_IDX_ZERO:  cfg_reg.zero_pos  <= cfg_data;
                fasp_pkg::CFG_IDX_HOME:  cfg_reg.home_pos  <= cfg_data;
                fasp_pkg::CFG_IDX_MAX:   cfg_reg.max_pos   <= cfg_data;
                fasp_pkg::CFG_IDX_START: cfg_reg.start_pos <= cfg_data;
                fasp_pkg::CFG_IDX_SHIFT: cfg_reg.pos_shift <= cfg_data[fasp_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // The front end takes a transfer whenever the queue has room, independent of m_tready.
    assign s_tready = !q_full;
    assign s_xfer   = s_tvalid && s_tready;

    fasp_front #(
        .AXES          (AXES),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .mode_in   (s_tuser[0]),
        .byte_in   (s_tdata),
        .pos_shift (cfg_reg.pos_shift),
        .cmd_out   (front_cmd),
        .pos_out   (front_pos)
    );

    fasp_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (fasp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_xfer),
        .push_data ({front_cmd, front_pos}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_data (head_entry)
    );

    assign head_cmd = head_entry[ENTRY_W-1:POSITION_BITS];
    assign head_pos = head_entry[POSITION_BITS-1:0];

    // The back end executes the queue head as soon as its output register can take a result.
    fasp_back #(
        .AXES          (AXES),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (q_not_empty),
        .item_pop   (q_pop),
        .item_cmd   (head_cmd),
        .item_pos   (head_pos),
        .cfg        (cfg_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
